/* src/aging_fifo_with_timeouts_core_assert.svh */
// Assertion macros for the aging FIFO block.
// Both expect clk_i and rst_ni in scope.
`ifndef AGING_FIFO_WITH_TIMEOUTS_CORE_ASSERT_SVH
`define AGING_FIFO_WITH_TIMEOUTS_CORE_ASSERT_SVH

// Same-cycle implication
`define AFT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication
`define AFT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

/* src/aft_pkg.sv */
package aft_pkg;

  localparam int unsigned QueueDepth = 16;
  localparam int unsigned HandleBits = 32;
  localparam int unsigned CountBits  = $clog2(QueueDepth + 1);

  localparam logic [31:0] DefaultTimeoutReset = 32'd5000;

  typedef enum logic [2:0] {
    FUNC_PUSH  = 3'd0,
    FUNC_COUNT = 3'd1,
    FUNC_POP   = 3'd2,
    FUNC_TICK  = 3'd3,
    FUNC_CLEAR = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MARK,
    ST_COMPACT,
    ST_EXEC
  } state_e;

  // One queue slot as seen by its neighbours
  typedef struct packed {
    logic                  valid;
    logic [HandleBits-1:0] handle;
    logic [31:0]           created;
    logic [31:0]           life;
  } cell_t;

  // Row-wide commands, at most one active per cycle
  typedef struct packed {
    logic clear;
    logic mark;
    logic compact;
    logic pop;
    logic push;
  } ctrl_t;

  function automatic logic [CountBits-1:0] count_valid(input logic [QueueDepth-1:0] v);
    logic [CountBits-1:0] acc;
    acc = '0;
    for (int unsigned i = 0; i < QueueDepth; i++) begin
      acc = acc + CountBits'(v[i]);
    end
    return acc;
  endfunction

endpackage

/* src/aft_stream_if.sv */
// Input transaction channel
interface aft_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [31:0] now_ms;
  logic [31:0] payload;
  logic [31:0] timeout_ms;
  logic        use_default;

  modport source (output valid, func, now_ms, payload, timeout_ms, use_default,
                  input ready);
  modport sink   (input valid, func, now_ms, payload, timeout_ms, use_default,
                  output ready);
endinterface

// Result transaction channel
interface aft_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [4:0]  entry_count;
  logic        pop_valid;
  logic [31:0] pop_payload;

  modport source (output valid, accepted, entry_count, pop_valid, pop_payload,
                  input ready);
  modport sink   (input valid, accepted, entry_count, pop_valid, pop_payload,
                  output ready);
endinterface

/* src/aft_cell.sv */
module aft_cell
  import aft_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ctrl_t       ctrl_i,
  input  logic [31:0] now_i,
  input  cell_t       new_i,
  input  cell_t       upper_i,
  input  logic        prev_valid_i,
  input  logic        hole_i,
  output cell_t       cell_o,
  output logic        hole_o
);

  logic                  valid_q, valid_d;
  logic [HandleBits-1:0] handle_q, handle_d;
  logic [31:0]           created_q, created_d;
  logic [31:0]           life_q, life_d;
  logic [31:0]           age;
  logic                  expired;
  logic                  take_upper;
  logic                  take_new;

  // wrap-around age against own lifetime
  assign age     = now_i - created_q;
  assign expired = (age >= life_q);

  // a hole here or below pulls the upper neighbour down during compaction
  assign hole_o     = hole_i | ~valid_q;
  assign take_upper = (ctrl_i.compact & hole_o) | ctrl_i.pop;
  // push lands in the first free slot only
  assign take_new   = ctrl_i.push & ~valid_q & prev_valid_i;

  always_comb begin
    valid_d   = valid_q;
    handle_d  = handle_q;
    created_d = created_q;
    life_d    = life_q;
    if (ctrl_i.clear) begin
      valid_d = 1'b0;
    end else if (ctrl_i.mark) begin
      if (expired) begin
        valid_d = 1'b0;
      end
    end else if (take_upper) begin
      valid_d   = upper_i.valid;
      handle_d  = upper_i.handle;
      created_d = upper_i.created;
      life_d    = upper_i.life;
    end else if (take_new) begin
      valid_d   = 1'b1;
      handle_d  = new_i.handle;
      created_d = new_i.created;
      life_d    = new_i.life;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // slot payload, no reset
  always_ff @(posedge clk_i) begin
    handle_q  <= handle_d;
    created_q <= created_d;
    life_q    <= life_d;
  end

  assign cell_o = '{valid: valid_q, handle: handle_q, created: created_q, life: life_q};

endmodule

/* src/aft_row.sv */
module aft_row
  import aft_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ctrl_t                 ctrl_i,
  input  logic [31:0]           now_i,
  input  cell_t                 new_i,
  output logic [QueueDepth-1:0] valid_o,
  output logic [HandleBits-1:0] head_handle_o
);

  cell_t cells [QueueDepth];
  logic  holes [QueueDepth+1];
  logic  prevs [QueueDepth];

  assign holes[0] = 1'b0;

  // chain of slots, oldest at cell 0
  for (genvar i = 0; i < QueueDepth; i++) begin : g_cell
    cell_t upper;
    if (i == QueueDepth - 1) begin : g_top
      assign upper = '0;
    end else begin : g_mid
      assign upper = cells[i+1];
    end
    if (i == 0) begin : g_first
      assign prevs[i] = 1'b1;
    end else begin : g_next
      assign prevs[i] = cells[i-1].valid;
    end

    aft_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl_i),
      .now_i        (now_i),
      .new_i        (new_i),
      .upper_i      (upper),
      .prev_valid_i (prevs[i]),
      .hole_i       (holes[i]),
      .cell_o       (cells[i]),
      .hole_o       (holes[i+1])
    );

    assign valid_o[i] = cells[i].valid;
  end

  assign head_handle_o = cells[0].handle;

endmodule

/* src/aging_fifo_with_timeouts_core.sv */
// Each input transaction is taken in idle only and then passes through expiry
// marking, compaction and execution; execution waits while a result is pending.
// No new transaction is taken before the last one has its result registered.
// Compaction removes one gap per cycle until no live slot sits above a gap.
// Reset: queue empty, default timeout 5000, no result pending; slot contents
// are not cleared.
`include "aging_fifo_with_timeouts_core_assert.svh"

module aging_fifo_with_timeouts_core
  import aft_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  aft_in_if.sink      in_i,
  aft_out_if.source   out_o
);

  state_e                state_q, state_d;
  logic [31:0]           dflt_q;
  logic [2:0]            func_q;
  logic [31:0]           now_q;
  logic [HandleBits-1:0] handle_q;
  logic [31:0]           life_q;

  logic                  out_valid_q;
  logic                  out_acc_q;
  logic [4:0]            out_cnt_q;
  logic                  out_popv_q;
  logic [31:0]           out_pay_q;

  ctrl_t                 ctrl;
  cell_t                 new_entry;
  logic [QueueDepth-1:0] valid;
  logic [HandleBits-1:0] head_handle;
  logic                  packed_row;
  logic                  out_free;
  logic                  exec_fire;
  logic                  full;
  logic [CountBits-1:0]  live;
  logic                  res_acc;
  logic                  res_popv;
  logic [CountBits-1:0]  res_cnt;

  assign out_free  = ~out_valid_q | out_o.ready;
  assign exec_fire = (state_q == ST_EXEC) & out_free;
  assign in_i.ready = (state_q == ST_IDLE);

  // default timeout register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dflt_q <= DefaultTimeoutReset;
    end else if (cfg_we_i) begin
      dflt_q <= cfg_wdata_i;
    end
  end

  // captured transaction
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      func_q   <= in_i.func;
      now_q    <= in_i.now_ms;
      handle_q <= HandleBits'(in_i.payload);
      life_q   <= in_i.use_default ? dflt_q : in_i.timeout_ms;
    end
  end

  // row is packed when no live slot sits above a gap
  always_comb begin
    packed_row = 1'b1;
    for (int unsigned i = 0; i + 1 < QueueDepth; i++) begin
      if (!valid[i] && valid[i+1]) begin
        packed_row = 1'b0;
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          state_d = ST_MARK;
        end
      end
      ST_MARK: begin
        state_d = ST_COMPACT;
      end
      ST_COMPACT: begin
        if (packed_row) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // row commands
  always_comb begin
    ctrl = '0;
    case (state_q)
      ST_MARK: begin
        ctrl.mark = 1'b1;
      end
      ST_COMPACT: begin
        ctrl.compact = 1'b1;
      end
      ST_EXEC: begin
        if (out_free) begin
          case (func_e'(func_q))
            FUNC_PUSH:  ctrl.push  = 1'b1;
            FUNC_POP:   ctrl.pop   = 1'b1;
            FUNC_CLEAR: ctrl.clear = 1'b1;
            default:    ctrl       = '0;
          endcase
        end
      end
      default: begin
        ctrl = '0;
      end
    endcase
  end

  assign new_entry = '{valid: 1'b1, handle: handle_q, created: now_q, life: life_q};

  aft_row u_row (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .now_i         (now_q),
    .new_i         (new_entry),
    .valid_o       (valid),
    .head_handle_o (head_handle)
  );

  // result of the operation on the packed row
  assign full     = valid[QueueDepth-1];
  assign live     = count_valid(valid);
  assign res_acc  = ctrl.push & ~full;
  assign res_popv = ctrl.pop & valid[0];

  always_comb begin
    res_cnt = live;
    if (ctrl.clear) begin
      res_cnt = '0;
    end else if (res_acc) begin
      res_cnt = live + CountBits'(1);
    end else if (res_popv) begin
      res_cnt = live - CountBits'(1);
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      out_acc_q  <= res_acc;
      out_cnt_q  <= 5'(res_cnt);
      out_popv_q <= res_popv;
      out_pay_q  <= res_popv ? 32'(head_handle) : 32'd0;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.accepted    = out_acc_q;
  assign out_o.entry_count = out_cnt_q;
  assign out_o.pop_valid   = out_popv_q;
  assign out_o.pop_payload = out_pay_q;

  `AFT_ASSERT_NOW(a_exec_packed, state_q == ST_EXEC, packed_row)
  `AFT_ASSERT_NOW(a_result_from_exec, $rose(out_valid_q), $past(state_q) == ST_EXEC)
  `AFT_ASSERT_NOW(a_mark_after_idle, state_q == ST_MARK, $past(state_q) == ST_IDLE)
  `AFT_ASSERT_NEXT(a_push_pop_excl, exec_fire, !(out_acc_q && out_popv_q))

endmodule
